/* hw/rtl/llti_pkg.sv */
package llti_pkg;

  localparam int TABLE_DEPTH_DEF   = 64;
  localparam int LOG_FRAC_BITS_DEF = 24;
  localparam int LOG_INT_BITS      = 8;
  localparam int TIME_FRAC         = 24;
  localparam int WEIGHT_BITS       = 24;
  localparam int MANT_FRAC         = 31;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_UNUSED = 2'd3
  } req_code_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_BAD   = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] position;
    logic [63:0] entry_time;
    logic [63:0] fallback_time;
  } req_t;

  typedef struct packed {
    logic [63:0] result_time;
    logic [1:0]  status;
  } rsp_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] b;
    x = x_in;
    r = 64'd0;
    b = 64'h4000_0000_0000_0000;
    for (int k = 0; k < 32; k++) begin
      if (b > x) b = b >> 2;
    end
    for (int k = 0; k < 32; k++) begin
      if (b != 64'd0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // root 2^(2^-n) in Q1.31, built by repeated square roots
  function automatic logic [63:0] exp2_root(input int n);
    logic [63:0] c;
    c = 64'h1_0000_0000;
    for (int k = 0; k < n; k++) begin
      c = isqrt64(c << 31);
    end
    return c;
  endfunction

endpackage

/* hw/rtl/llti_mem.sv */
module llti_mem #(
  parameter int WIDTH = 160,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/llti_log2.sv */
module llti_log2 #(
  parameter int FRAC  = llti_pkg::LOG_FRAC_BITS_DEF,
  parameter int LOG_W = llti_pkg::LOG_INT_BITS + llti_pkg::LOG_FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [63:0]      t,
  output logic             done,
  output logic [LOG_W-1:0] log_val
);

  localparam int CNT_W = $clog2(FRAC);

  typedef enum logic [2:0] {
    L_IDLE = 3'b001,
    L_NORM = 3'b010,
    L_SQ   = 3'b100
  } lstate_t;

  lstate_t          state;
  logic [63:0]      norm;
  logic [63:0]      norm_next;
  logic [2:0]       ncnt;
  logic [5:0]       p;
  logic [6:0]       sh;
  logic             top_zero;
  logic [31:0]      m;
  logic [63:0]      prod;
  logic [32:0]      msq;
  logic [FRAC-1:0]  frac;
  logic [CNT_W-1:0] cnt;

  always_comb begin
    sh        = 7'd32 >> ncnt;
    top_zero  = (norm >> (7'd64 - sh)) == 64'd0;
    norm_next = top_zero ? (norm << sh) : norm;
    prod      = 64'(m) * 64'(m);
    msq       = prod[63:31];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      done  <= 1'b0;
    end else begin
      done <= state == L_SQ && cnt == CNT_W'(FRAC - 1);
      unique case (state)
        L_IDLE: begin
          if (start) begin
            norm  <= t;
            p     <= 6'd63;
            ncnt  <= 3'd0;
            state <= L_NORM;
          end
        end
        L_NORM: begin
          norm <= norm_next;
          if (top_zero) p <= p - sh[5:0];
          ncnt <= ncnt + 3'd1;
          if (ncnt == 3'd5) begin
            m     <= norm_next[63:32];
            cnt   <= '0;
            state <= L_SQ;
          end
        end
        L_SQ: begin
          m    <= msq[32] ? msq[32:1] : msq[31:0];
          frac <= {frac[FRAC-2:0], msq[32]};
          cnt  <= cnt + 1'b1;
          if (cnt == CNT_W'(FRAC - 1)) state <= L_IDLE;
        end
        default: state <= L_IDLE;
      endcase
    end
  end

  assign log_val = {LOG_W'(8'(p) - 8'(llti_pkg::TIME_FRAC))} << FRAC | LOG_W'(frac);

endmodule

/* hw/rtl/llti_interp.sv */
module llti_interp #(
  parameter int W = llti_pkg::LOG_INT_BITS + llti_pkg::LOG_FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [31:0]  num,
  input  logic [31:0]  den,
  input  logic [W-1:0] absd,
  output logic         done,
  output logic [W-1:0] mag
);

  localparam int WB    = llti_pkg::WEIGHT_BITS;
  localparam int CNT_W = $clog2(WB);

  typedef enum logic [1:0] {
    I_IDLE = 2'b01,
    I_RUN  = 2'b10
  } istate_t;

  istate_t          state;
  logic [31:0]      r;
  logic [31:0]      b;
  logic [W-1:0]     d;
  logic [W+WB-1:0]  acc;
  logic [CNT_W-1:0] cnt;
  logic [32:0]      r2;
  logic             ge;

  always_comb begin
    r2 = {r, 1'b0};
    ge = r2 >= {1'b0, b};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= I_IDLE;
      done  <= 1'b0;
    end else begin
      done <= state == I_RUN && cnt == CNT_W'(WB - 1);
      unique case (state)
        I_IDLE: begin
          if (start) begin
            r     <= num;
            b     <= den;
            d     <= absd;
            acc   <= '0;
            cnt   <= '0;
            state <= I_RUN;
          end
        end
        I_RUN: begin
          r   <= ge ? 32'(r2 - {1'b0, b}) : r2[31:0];
          acc <= (acc << 1) + (ge ? (W + WB)'(d) : '0);
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(WB - 1)) state <= I_IDLE;
        end
        default: state <= I_IDLE;
      endcase
    end
  end

  assign mag = acc[W+WB-1:WB];

endmodule

/* hw/rtl/llti_exp2.sv */
module llti_exp2 #(
  parameter int FRAC  = llti_pkg::LOG_FRAC_BITS_DEF,
  parameter int LOG_W = llti_pkg::LOG_INT_BITS + llti_pkg::LOG_FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [LOG_W-1:0] l,
  output logic             done,
  output logic [63:0]      res
);

  localparam int CNT_W = $clog2(FRAC);
  localparam int IW    = llti_pkg::LOG_INT_BITS;

  typedef enum logic [2:0] {
    E_IDLE = 3'b001,
    E_MUL  = 3'b010,
    E_SH   = 3'b100
  } estate_t;

  estate_t            state;
  logic [31:0]        ctab [FRAC];
  logic [31:0]        m;
  logic [FRAC-1:0]    f;
  logic signed [IW-1:0] ip;
  logic [CNT_W-1:0]   cnt;
  logic [63:0]        prod;
  logic signed [IW:0] s;
  logic [IW:0]        ns;
  logic [95:0]        ext;
  logic [63:0]        sh_res;

  for (genvar g = 0; g < FRAC; g++) begin : g_ctab
    localparam logic [63:0] CV = llti_pkg::exp2_root(g + 1);
    assign ctab[g] = CV[31:0];
  end

  always_comb begin
    prod = 64'(m) * 64'(ctab[cnt]);
    s    = $signed({ip[IW-1], ip}) - (IW + 1)'(llti_pkg::MANT_FRAC - llti_pkg::TIME_FRAC);
    ns   = (IW + 1)'(-s);
    ext  = 96'(m) << s[5:0];
    if (ip > IW'(64)) begin
      sh_res = '1;
    end else if (!s[IW]) begin
      if (s > (IW + 1)'(32) || ext[95:64] != 32'd0) sh_res = '1;
      else sh_res = ext[63:0];
    end else if (ns >= (IW + 1)'(32)) begin
      sh_res = '0;
    end else begin
      sh_res = 64'(m) >> ns[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
      done  <= 1'b0;
    end else begin
      done <= state == E_SH;
      unique case (state)
        E_IDLE: begin
          if (start) begin
            ip    <= l[LOG_W-1:FRAC];
            f     <= l[FRAC-1:0];
            m     <= 32'h8000_0000;
            cnt   <= '0;
            state <= E_MUL;
          end
        end
        E_MUL: begin
          if (f[FRAC-1]) m <= prod[62:31];
          f   <= f << 1;
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(FRAC - 1)) state <= E_SH;
        end
        E_SH: begin
          res   <= sh_res;
          state <= E_IDLE;
        end
        default: state <= E_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/log_linear_table_interpolator_top.sv */
// clear and unused codes and empty-table queries go straight to the response
// append: its duration is set by the iterative log2 unit
// query: one table read per cycle in the scan, 24 divider steps, one exp2
// multiply per fraction bit
// one request at a time; the next is taken while the last result waits
// synchronous reset clears the entry count and control; table contents stay
module log_linear_table_interpolator_top #(
  parameter int TABLE_DEPTH   = llti_pkg::TABLE_DEPTH_DEF,
  parameter int LOG_FRAC_BITS = llti_pkg::LOG_FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  llti_pkg::req_t   req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output llti_pkg::rsp_t   rsp
);

  localparam int LOG_W   = llti_pkg::LOG_INT_BITS + LOG_FRAC_BITS;
  localparam int ENTRY_W = 32 + 64 + LOG_W;
  localparam int AW      = $clog2(TABLE_DEPTH);
  localparam int CW      = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_LOG  = 9'b000000010,
    S_RD0  = 9'b000000100,
    S_CHK0 = 9'b000001000,
    S_CHKL = 9'b000010000,
    S_SCAN = 9'b000100000,
    S_DIV  = 9'b001000000,
    S_EXP  = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

  state_t             state;
  logic [CW-1:0]      count;
  logic [31:0]        last_pos;
  llti_pkg::req_t     req_q;
  logic [63:0]        res;
  llti_pkg::status_t  st;
  logic [31:0]        prev_pos;
  logic [63:0]        prev_time;
  logic [LOG_W-1:0]   prev_log;
  logic [AW-1:0]      scan_idx;
  logic               dneg;

  logic               mem_we;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [ENTRY_W-1:0] mem_rdata;
  logic [31:0]        rpos;
  logic [63:0]        rtime;
  logic [LOG_W-1:0]   rlog;

  logic               log_start;
  logic               log_done;
  logic [LOG_W-1:0]   log_val;
  logic               div_start;
  logic               div_done;
  logic [LOG_W-1:0]   mag;
  logic               exp_start;
  logic               exp_done;
  logic [63:0]        exp_res;
  logic [LOG_W:0]     dlog;
  logic [LOG_W-1:0]   absd;
  logic [LOG_W-1:0]   lsum;
  logic               append_ok;
  logic               found;

  assign req_ready = (state == S_IDLE);
  assign {rpos, rtime, rlog} = mem_rdata;

  always_comb begin
    append_ok = !(count >= CW'(TABLE_DEPTH)) && req.entry_time != 64'd0 &&
                !(count != '0 && req.position < last_pos);
    log_start = req_valid && state == S_IDLE &&
                req.req_type == llti_pkg::REQ_APPEND && append_ok;
    found     = state == S_SCAN && req_q.position < rpos;
    dlog      = {rlog[LOG_W-1], rlog} - {prev_log[LOG_W-1], prev_log};
    absd      = dlog[LOG_W] ? LOG_W'(-dlog) : dlog[LOG_W-1:0];
    div_start = found && req_q.position != prev_pos && rpos > prev_pos;
    lsum      = dneg ? prev_log - mag : prev_log + mag;
    exp_start = state == S_DIV && div_done;
    mem_we    = state == S_LOG && log_done;
    mem_re    = 1'b0;
    mem_raddr = '0;
    unique case (state)
      S_RD0: mem_re = 1'b1;
      S_CHK0: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(count - 1'b1);
      end
      S_CHKL: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(1);
      end
      S_SCAN: begin
        mem_re    = 1'b1;
        mem_raddr = scan_idx + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && state != S_DONE) rsp_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            req_q <= req;
            unique case (req.req_type)
              llti_pkg::REQ_CLEAR: begin
                count <= '0;
                res   <= '0;
                st    <= llti_pkg::ST_OK;
                state <= S_DONE;
              end
              llti_pkg::REQ_APPEND: begin
                res <= '0;
                if (count >= CW'(TABLE_DEPTH)) begin
                  st    <= llti_pkg::ST_FULL;
                  state <= S_DONE;
                end else if (!append_ok) begin
                  st    <= llti_pkg::ST_BAD;
                  state <= S_DONE;
                end else begin
                  st    <= llti_pkg::ST_OK;
                  state <= S_LOG;
                end
              end
              llti_pkg::REQ_QUERY: begin
                if (count == '0) begin
                  res   <= req.fallback_time;
                  st    <= llti_pkg::ST_EMPTY;
                  state <= S_DONE;
                end else begin
                  res   <= '0;
                  st    <= llti_pkg::ST_OK;
                  state <= S_RD0;
                end
              end
              default: begin
                res   <= '0;
                st    <= llti_pkg::ST_OK;
                state <= S_DONE;
              end
            endcase
          end
        end
        S_LOG: begin
          if (log_done) begin
            count    <= count + 1'b1;
            last_pos <= req_q.position;
            state    <= S_DONE;
          end
        end
        S_RD0: state <= S_CHK0;
        S_CHK0: begin
          prev_pos  <= rpos;
          prev_time <= rtime;
          prev_log  <= rlog;
          if (req_q.position <= rpos) begin
            res   <= rtime;
            state <= S_DONE;
          end else begin
            state <= S_CHKL;
          end
        end
        S_CHKL: begin
          if (req_q.position >= rpos) begin
            res   <= rtime;
            state <= S_DONE;
          end else begin
            scan_idx <= AW'(1);
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (found) begin
            dneg <= dlog[LOG_W];
            if (div_start) begin
              state <= S_DIV;
            end else begin
              res   <= prev_time;
              state <= S_DONE;
            end
          end else begin
            prev_pos  <= rpos;
            prev_time <= rtime;
            prev_log  <= rlog;
            scan_idx  <= scan_idx + 1'b1;
          end
        end
        S_DIV: if (div_done) state <= S_EXP;
        S_EXP: begin
          if (exp_done) begin
            res   <= exp_res;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!rsp_valid || rsp_ready)) begin
      rsp.result_time <= res;
      rsp.status      <= st;
    end
  end

  llti_mem #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (count[AW-1:0]),
    .wdata ({req_q.position, req_q.entry_time, log_val}),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  llti_log2 #(
    .FRAC  (LOG_FRAC_BITS),
    .LOG_W (LOG_W)
  ) u_log2 (
    .clk     (clk),
    .rst     (rst),
    .start   (log_start),
    .t       (req.entry_time),
    .done    (log_done),
    .log_val (log_val)
  );

  llti_interp #(
    .W (LOG_W)
  ) u_interp (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (req_q.position - prev_pos),
    .den   (rpos - prev_pos),
    .absd  (absd),
    .done  (div_done),
    .mag   (mag)
  );

  llti_exp2 #(
    .FRAC  (LOG_FRAC_BITS),
    .LOG_W (LOG_W)
  ) u_exp2 (
    .clk   (clk),
    .rst   (rst),
    .start (exp_start),
    .l     (lsum),
    .done  (exp_done),
    .res   (exp_res)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH))
    else $error("entry count past table depth");

  a_write_bumps: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> count == $past(count) + 1'b1)
    else $error("table write without count step");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req.req_type == llti_pkg::REQ_CLEAR |=> count == '0)
    else $error("clear left entries");

  a_exp_done: assert property (@(posedge clk) disable iff (rst)
    exp_done |-> state == S_EXP)
    else $error("exp2 finished outside its wait");

endmodule

/* dv/llti_checker.sv */
`timescale 1ns / 100ps
module llti_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_ready,
  input  llti_pkg::req_t req,
  input  logic           rsp_valid,
  input  logic           rsp_ready,
  input  llti_pkg::rsp_t rsp,
  output int             fail_count,
  output int             pending_count
);

  localparam int DEPTH = llti_pkg::TABLE_DEPTH_DEF;
  localparam int LFB   = llti_pkg::LOG_FRAC_BITS_DEF;

  logic [31:0]        pos_tab [DEPTH];
  logic [63:0]        time_tab [DEPTH];
  logic signed [63:0] log_tab [DEPTH];
  int                 count;
  llti_pkg::rsp_t     expected_rsps [$];
  int                 mismatches;

  function automatic logic [63:0] sqrt_floor(input logic [63:0] x_in);
    logic [63:0] x, r, b;
    x = x_in;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [63:0] log2_fixed(input logic [63:0] t);
    int p;
    logic [63:0] m, frac;
    logic [127:0] sq;
    p = 63;
    frac = 0;
    while (p > 0 && t[p] == 1'b0) p--;
    if (p >= 31) m = t >> (p - 31);
    else m = t << (31 - p);
    for (int i = LFB - 1; i >= 0; i--) begin
      sq = m * m;
      m = sq[63+31:31];
      if (m >= 64'h1_0000_0000) begin
        frac[i] = 1'b1;
        m = m >> 1;
      end
    end
    return (64'(signed'(p - llti_pkg::TIME_FRAC)) <<< LFB) + $signed(frac);
  endfunction

  function automatic logic [63:0] exp2_fixed(input logic signed [63:0] l);
    logic signed [63:0] ip;
    logic [63:0] f, m, c, u, mask;
    logic [127:0] pr;
    int s;
    mask = (64'd1 << LFB) - 1;
    m = 64'd1 << 31;
    c = 64'd1 << 32;
    if (l >= 0) begin
      ip = $signed(64'(l) >> LFB);
    end else begin
      u = -l;
      ip = -$signed((u + mask) >> LFB);
    end
    f = l - (ip <<< LFB);
    for (int i = LFB - 1; i >= 0; i--) begin
      c = sqrt_floor(c << 31);
      if (f[i]) begin
        pr = m * c;
        m = pr[63+31:31];
      end
    end
    if (ip > 64) return '1;
    if (ip < -128) return 0;
    s = int'(ip) + llti_pkg::TIME_FRAC - 31;
    if (s >= 0) begin
      if (s > 32) return '1;
      if (s > 0 && (m >> (64 - s)) != 0) return '1;
      return m << s;
    end
    if (s <= -64) return 0;
    return m >> (-s);
  endfunction

  function automatic logic [63:0] interp_time(input logic [31:0] q);
    int k;
    logic [31:0] p0, p1;
    logic signed [63:0] d;
    logic [63:0] w, mag;
    logic [127:0] pr;
    k = 1;
    if (q <= pos_tab[0]) return time_tab[0];
    if (q >= pos_tab[count-1]) return time_tab[count-1];
    for (int i = count - 1; i >= 1; i--) if (q < pos_tab[i]) k = i;
    p0 = pos_tab[k-1];
    p1 = pos_tab[k];
    if (q == p0 || p1 <= p0) return time_tab[k-1];
    w = ({32'd0, q - p0} << 32) / {32'd0, p1 - p0};
    w = w >> (32 - llti_pkg::WEIGHT_BITS);
    d = log_tab[k] - log_tab[k-1];
    mag = (d < 0) ? -d : d;
    pr = mag * w;
    mag = pr[63+llti_pkg::WEIGHT_BITS:llti_pkg::WEIGHT_BITS];
    return exp2_fixed(log_tab[k-1] + ((d < 0) ? -$signed(mag) : $signed(mag)));
  endfunction

  function automatic llti_pkg::rsp_t apply_request(input llti_pkg::req_t r);
    llti_pkg::rsp_t o;
    o.result_time = 0;
    o.status = llti_pkg::ST_OK;
    case (r.req_type)
      llti_pkg::REQ_CLEAR: count = 0;
      llti_pkg::REQ_APPEND: begin
        if (count >= DEPTH) o.status = llti_pkg::ST_FULL;
        else if (r.entry_time == 0 || (count > 0 && r.position < pos_tab[count-1]))
          o.status = llti_pkg::ST_BAD;
        else begin
          pos_tab[count] = r.position;
          time_tab[count] = r.entry_time;
          log_tab[count] = log2_fixed(r.entry_time);
          count++;
        end
      end
      llti_pkg::REQ_QUERY: begin
        if (count == 0) begin
          o.result_time = r.fallback_time;
          o.status = llti_pkg::ST_EMPTY;
        end else begin
          o.result_time = interp_time(r.position);
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  assign pending_count = expected_rsps.size();

  always @(posedge clk) begin
    llti_pkg::rsp_t e;
    if (rst) begin
      count = 0;
      fail_count <= 0;
      mismatches = 0;
      expected_rsps.delete();
    end else begin
      if (req_valid && req_ready) expected_rsps.push_back(apply_request(req));
      if (rsp_valid && rsp_ready) begin
        if (expected_rsps.size() == 0) begin
          fail_count <= fail_count + 1;
          if (mismatches < 10) $display("unexpected beat: %h %0d", rsp.result_time, rsp.status);
          mismatches++;
        end else begin
          e = expected_rsps.pop_front();
          if (e.result_time !== rsp.result_time || e.status !== rsp.status) begin
            fail_count <= fail_count + 1;
            if (mismatches < 10)
              $display("mismatch: exp %h/%0d got %h/%0d",
                       e.result_time, e.status, rsp.result_time, rsp.status);
            mismatches++;
          end
        end
      end
    end
  end
endmodule

/* dv/log_linear_table_interpolator_top_test.sv */
`timescale 1ns / 100ps
module log_linear_table_interpolator_top_test;

  logic clk = 0;
  logic rst = 1;
  logic req_valid = 0;
  logic req_ready;
  llti_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 0;
  llti_pkg::rsp_t rsp;
  int   fail_count, pending_count;
  int   idle_cycles = 0;
  bit   no_idle = 0;
  logic [31:0] last_pos;

  always #4 clk = ~clk;

  log_linear_table_interpolator_top dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  llti_checker checker_i (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(negedge clk) rsp_ready <= no_idle || ($urandom_range(99) >= 35);

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // valid stays high after a beat until the next beat or an idle cycle
  task automatic send(input logic [1:0] t, input logic [31:0] p,
                      input logic [63:0] et, input logic [63:0] fb);
    while (!no_idle && $urandom_range(99) < 35) begin
      req_valid <= 0;
      @(negedge clk);
    end
    req <= '{t, p, et, fb};
    req_valid <= 1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_time(output logic [63:0] t);
    case ($urandom_range(3))
      0: t = rand64();
      1: t = {32'd0, $urandom};
      2: t = 64'd1 << $urandom_range(63);
      default: t = 64'($urandom_range(1 << 20)) + 1;
    endcase
  endtask

  initial begin
    logic [63:0] t;
    logic [31:0] p;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    send(llti_pkg::REQ_QUERY, 32'h1234, 0, '1);
    send(llti_pkg::REQ_APPEND, 32'h10000, 0, 0);
    send(llti_pkg::REQ_APPEND, 32'h10000, 64'd1 << 24, 0);
    send(llti_pkg::REQ_QUERY, 32'h10000, 0, 0);
    send(llti_pkg::REQ_APPEND, 32'h20000, 64'd8 << 24, 0);
    send(llti_pkg::REQ_APPEND, 32'h18000, 64'd2, 0);
    send(llti_pkg::REQ_QUERY, 32'h0, 0, 0);
    send(llti_pkg::REQ_QUERY, 32'h18000, 0, 0);
    send(llti_pkg::REQ_QUERY, '1, 0, 0);
    send(llti_pkg::REQ_APPEND, 32'h20000, '1, 0);
    send(llti_pkg::REQ_APPEND, '1, 64'd1, 0);
    send(llti_pkg::REQ_QUERY, 32'h20001, 0, 0);
    send(llti_pkg::REQ_QUERY, 32'h30000, 0, 0);
    send(llti_pkg::REQ_UNUSED, '1, '1, '1);
    send(llti_pkg::REQ_CLEAR, '1, '1, '1);
    for (int i = 0; i < 64; i++) send(llti_pkg::REQ_APPEND, 32'(i) << 20, 64'd1 << i, 0);
    send(llti_pkg::REQ_APPEND, '1, 1, 0);
    send(llti_pkg::REQ_QUERY, 32'h0208_0000, 0, 0);
    send(llti_pkg::REQ_QUERY, 32'h3E8_0000, 0, 0);
    for (int s = 0; s < 21; s++) begin
      no_idle = (s >= 10 && s < 14);
      send(llti_pkg::REQ_CLEAR, $urandom, rand64(), rand64());
      last_pos = 0;
      repeat ($urandom_range(1, (s % 6 == 0) ? 64 : 8)) begin
        random_time(t);
        if ($urandom_range(9) == 0) t = 0;
        p = last_pos + (($urandom_range(3) == 0) ? 0 : $urandom_range(1 << 24));
        if ($urandom_range(19) == 0) p = $urandom;
        if (p < last_pos) p = $urandom;
        send(llti_pkg::REQ_APPEND, p, t, rand64());
        if (t != 0 && p >= last_pos) last_pos = p;
      end
      repeat ($urandom_range(4, 10)) begin
        p = ($urandom_range(5) == 0) ? $urandom : $urandom_range(last_pos + 10);
        send(llti_pkg::REQ_QUERY, p, rand64(), rand64());
      end
      if ($urandom_range(3) == 0) send(2'($urandom_range(3)), $urandom, rand64(), rand64());
    end
    req_valid <= 0;
    no_idle = 0;
    while (pending_count != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
